FILE: rtl/core/vrpv_pkg.sv
// Shared types, widths and constants of the vertex rotate, project and viewport pipeline.
`default_nettype none

package vrpv_pkg;

  // Defaults of the top-level parameters.
  localparam int WINDOW_WIDTH_DEF    = 600;
  localparam int WINDOW_HEIGHT_DEF   = 600;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // Field and register widths.
  localparam int COORD_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_ANGLE = 1'b0,
    CFG_CAM_DIST  = 1'b1
  } cfg_idx_e;

  localparam logic        [CFG_W-1:0] ROT_RESET = 16'd0;
  localparam logic signed [CFG_W-1:0] CAM_RESET = 16'sd5120;

  // Internal datapath widths, sized for the largest window.
  localparam int PROD_W    = 32;
  localparam int XR_W      = 33;
  localparam int D_W       = 34;
  localparam int NUM_W     = 48;
  localparam int DEN_W     = 35;
  localparam int REM_W     = 51;
  localparam int QUO_W     = 16;
  localparam int DIV_STEPS = 16;

  // Pipeline layout: three front stages, the divider, one output stage.
  localparam int FRONT_STAGES = 3;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + 2;

  // Near limit of depth in Q27, about 0.001.
  localparam logic signed [D_W-1:0] NEAR_LIMIT = 34'sd134218;

  // Quarter-wave sine polynomial coefficients in Q30.
  localparam longint SIN_C1 = 64'sd1686629713;
  localparam longint SIN_C3 = 64'sd693598669;
  localparam longint SIN_C5 = 64'sd85569306;
  localparam longint SIN_C7 = 64'sd5026995;
  localparam longint SIN_C9 = 64'sd172272;

  // Request handed from the transform front end to the dividers.
  typedef struct packed {
    logic signed [NUM_W-1:0] col_num;
    logic signed [NUM_W-1:0] row_num;
    logic        [DEN_W-1:0] den;
    logic                    clamped;
  } proj_t;

endpackage

`default_nettype wire

FILE: rtl/core/vrpv_cfg.sv
// Configuration registers and the sine and cosine lookup of the rotation angle.
`default_nettype none

module vrpv_cfg
  import vrpv_pkg::*;
#(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_W-1:0]            cfg_wdata_i,
  output logic signed [COORD_W-1:0]        sin_o,
  output logic signed [COORD_W-1:0]        cos_o,
  output logic signed [CFG_W-1:0]          cam_dist_o
);

  localparam int QN = 1 << (SINE_TABLE_BITS - 2);

  typedef logic [14:0] qtab_t [QN+1];

  // Quarter-wave sine in Q14 of a quarter-turn fraction t in 0..16384.
  function automatic logic [14:0] quarter_sine(longint t);
    longint x2;
    longint p;
    longint r;
    x2 = (t * t) <<< 2;
    p  = SIN_C9;
    p  = SIN_C7 - ((p * x2) >>> 30);
    p  = SIN_C5 - ((p * x2) >>> 30);
    p  = SIN_C3 - ((p * x2) >>> 30);
    p  = SIN_C1 - ((p * x2) >>> 30);
    r  = (p * t + (64'sd1 <<< 29)) >>> 30;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < 64'sd0) r = 64'sd0;
    return r[14:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int i = 0; i <= QN; i++) begin
      tab[i] = quarter_sine(longint'(i) <<< (16 - SINE_TABLE_BITS));
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // Full-turn sine from the quarter table by mirroring and sign.
  function automatic logic signed [COORD_W-1:0] sine_at(logic [SINE_TABLE_BITS-1:0] kk);
    logic [SINE_TABLE_BITS-2:0] j;
    logic signed [COORD_W-1:0]  v;
    j = {1'b0, kk[SINE_TABLE_BITS-3:0]};
    if (kk[SINE_TABLE_BITS-2]) j = (SINE_TABLE_BITS-1)'(QN) - j;
    v = $signed({1'b0, QTAB[j]});
    if (kk[SINE_TABLE_BITS-1]) v = -v;
    return v;
  endfunction

  logic        [CFG_W-1:0]           rot_q;
  logic        [CFG_W-1:0]           rot_d;
  logic signed [CFG_W-1:0]           cam_q;
  logic        [SINE_TABLE_BITS-1:0] k;
  logic        [SINE_TABLE_BITS-1:0] kc;
  logic signed [COORD_W-1:0]         sin_d, cos_d, sin_q, cos_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= ROT_RESET;
      cam_q <= CAM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ROT_ANGLE: rot_q <= cfg_wdata_i;
        CFG_CAM_DIST:  cam_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Table lookup of the angle being loaded, so that sine and cosine change at the
  // same edge as the angle; the angle is truncated to the table step and cosine is
  // a quarter turn ahead.
  always_comb begin
    rot_d = rot_q;
    if (cfg_we_i && (cfg_idx_e'(cfg_index_i) == CFG_ROT_ANGLE)) rot_d = cfg_wdata_i;
    k     = rot_d[CFG_W-1 -: SINE_TABLE_BITS];
    kc    = k + SINE_TABLE_BITS'(QN);
    sin_d = sine_at(k);
    cos_d = sine_at(kc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_q <= 16'sd0;
      cos_q <= 16'sd16384;
    end else begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o      = sin_q;
  assign cos_o      = cos_q;
  assign cam_dist_o = cam_q;

endmodule

`default_nettype wire

FILE: rtl/core/vrpv_front.sv
// Front end: rotation products, depth sum with near clamp, and scaled numerators.
`default_nettype none

module vrpv_front
  import vrpv_pkg::*;
#(
  parameter int WINDOW_WIDTH  = WINDOW_WIDTH_DEF,
  parameter int WINDOW_HEIGHT = WINDOW_HEIGHT_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic [FRONT_STAGES-1:0]   en_i,
  input  wire logic signed [COORD_W-1:0] vx_i,
  input  wire logic signed [COORD_W-1:0] vy_i,
  input  wire logic signed [COORD_W-1:0] vz_i,
  input  wire logic signed [COORD_W-1:0] sin_i,
  input  wire logic signed [COORD_W-1:0] cos_i,
  input  wire logic signed [CFG_W-1:0]   cam_dist_i,
  output proj_t                          proj_o
);

  localparam logic signed [NUM_W-1:0] WW = NUM_W'(WINDOW_WIDTH);
  localparam logic signed [NUM_W-1:0] HH = NUM_W'(WINDOW_HEIGHT);

  logic signed [PROD_W-1:0]  xc_q, zs_q, xs_q, zc_q;
  logic signed [COORD_W-1:0] y1_q, y2_q;
  logic signed [CFG_W-1:0]   cam_q;
  logic signed [XR_W-1:0]    xr_d, xr_q;
  logic signed [D_W-1:0]     dsum, d_d, d_q;
  logic                      clamp_d, clamp_q;
  proj_t                     proj_d, proj_q;

  // First stage: the four rotation products.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      xc_q  <= vx_i * cos_i;
      zs_q  <= vz_i * sin_i;
      xs_q  <= vx_i * sin_i;
      zc_q  <= vz_i * cos_i;
      y1_q  <= vy_i;
      cam_q <= cam_dist_i;
    end
  end

  // Second stage: rotated x and depth, depth raised to the near limit.
  always_comb begin
    xr_d    = XR_W'(xc_q) - XR_W'(zs_q);
    dsum    = D_W'(xs_q) + D_W'(zc_q) + (D_W'(cam_q) <<< 16);
    clamp_d = (dsum <= NEAR_LIMIT);
    d_d     = clamp_d ? NEAR_LIMIT : dsum;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      xr_q    <= xr_d;
      d_q     <= d_d;
      clamp_q <= clamp_d;
      y2_q    <= y1_q;
    end
  end

  // Third stage: viewport numerators and the doubled depth as divisor.
  always_comb begin
    proj_d.col_num = (NUM_W'(xr_q) + NUM_W'(d_q)) * WW;
    proj_d.row_num = (NUM_W'(d_q) - (NUM_W'(y2_q) <<< 14)) * HH;
    proj_d.den     = {d_q, 1'b0};
    proj_d.clamped = clamp_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      proj_q <= proj_d;
    end
  end

  assign proj_o = proj_q;

endmodule

`default_nettype wire

FILE: rtl/core/vrpv_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
`default_nettype none

module vrpv_div
  import vrpv_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic [DIV_STEPS:0]      en_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0]        den_i,
  output logic [QUO_W-1:0]             mag_o,
  output logic                         neg_o,
  output logic                         ovf_o
);

  logic [REM_W-1:0] rem_q [DIV_STEPS+1];
  logic [DEN_W-1:0] den_q [DIV_STEPS+1];
  logic [QUO_W-1:0] quo_q [DIV_STEPS+1];
  logic             neg_q [DIV_STEPS+1];
  logic             ovf_q [DIV_STEPS+1];

  logic [NUM_W-1:0] mag;
  logic [REM_W-1:0] rem0;

  // Entry stage: magnitude of the numerator and the check that the quotient fits.
  always_comb begin
    mag  = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    rem0 = REM_W'(mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= rem0;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= num_i[NUM_W-1];
      ovf_q[0] <= (rem0 >= (REM_W'(den_i) << DIV_STEPS));
    end
  end

  // One trial subtraction per stage, most significant quotient bit first.
  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
    logic [REM_W-1:0] trial;
    logic             take;

    always_comb begin
      trial = REM_W'(den_q[i-1]) << (DIV_STEPS - i);
      take  = (rem_q[i-1] >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        rem_q[i] <= take ? (rem_q[i-1] - trial) : rem_q[i-1];
        den_q[i] <= den_q[i-1];
        quo_q[i] <= {quo_q[i-1][QUO_W-2:0], take};
        neg_q[i] <= neg_q[i-1];
        ovf_q[i] <= ovf_q[i-1];
      end
    end
  end

  assign mag_o = quo_q[DIV_STEPS];
  assign neg_o = neg_q[DIV_STEPS];
  assign ovf_o = ovf_q[DIV_STEPS];

endmodule

`default_nettype wire

FILE: rtl/core/vertex_rotate_project_viewport_top.sv
// Top level of the vertex rotate, perspective project and viewport pipeline.
`default_nettype none

// Takes one signed Q2.13 vertex per request, rotates it about the vertical
// axis by the configured angle, adds the camera distance to depth, raises
// depth to the near limit, and maps x/d and -y/d to window pixels, truncated
// toward zero and saturated to signed 16 bits. One vertex is accepted every
// clock cycle while the output is taken or some stage is empty; the pipeline
// holds twenty-one register stages: the three transform stages, the sixteen
// one-bit divider stages plus their entry stage, and the output register.
// Stages holding no valid request absorb stalls, so input is taken while a
// result waits. A configuration write is used by vertices accepted from the
// next cycle on.
module vertex_rotate_project_viewport_top
  import vrpv_pkg::*;
#(
  parameter int WINDOW_WIDTH    = WINDOW_WIDTH_DEF,
  parameter int WINDOW_HEIGHT   = WINDOW_HEIGHT_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // vertex_x [15:0], vertex_y [31:16], vertex_z [47:32]
  input  wire logic [47:0]          s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // screen_x [15:0], screen_y [31:16]
  output logic [31:0]               m_axis_tdata,
  // near_clamped [0]
  output logic                      m_axis_tuser
);

  logic [NUM_STAGES-1:0]            v_q;
  logic [NUM_STAGES-1:0]            v_in;
  logic [NUM_STAGES-1:0]            rdy;
  logic [NUM_STAGES-1:FRONT_STAGES] clamp_q;

  logic signed [COORD_W-1:0] sin_w, cos_w;
  logic signed [CFG_W-1:0]   cam_w;
  proj_t                     proj;
  logic [QUO_W-1:0]          cmag, rmag;
  logic                      cneg, rneg, covf, rovf;
  logic signed [COORD_W-1:0] sx_q, sy_q;

  // A stage loads when it is empty or everything after it can move.
  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_rdy
    assign rdy[i] = m_axis_tready | ~(&v_q[NUM_STAGES-1:i]);
  end

  assign v_in          = {v_q[NUM_STAGES-2:0], s_axis_tvalid};
  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (rdy[i]) v_q[i] <= v_in[i];
      end
    end
  end

  vrpv_cfg #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sin_o      (sin_w),
    .cos_o      (cos_w),
    .cam_dist_o (cam_w)
  );

  vrpv_front #(
    .WINDOW_WIDTH (WINDOW_WIDTH),
    .WINDOW_HEIGHT(WINDOW_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .en_i      (rdy[FRONT_STAGES-1:0]),
    .vx_i      ($signed(s_axis_tdata[15:0])),
    .vy_i      ($signed(s_axis_tdata[31:16])),
    .vz_i      ($signed(s_axis_tdata[47:32])),
    .sin_i     (sin_w),
    .cos_i     (cos_w),
    .cam_dist_i(cam_w),
    .proj_o    (proj)
  );

  vrpv_div u_div_col (
    .clk_i(clk_i),
    .en_i (rdy[FRONT_STAGES +: DIV_STEPS+1]),
    .num_i(proj.col_num),
    .den_i(proj.den),
    .mag_o(cmag),
    .neg_o(cneg),
    .ovf_o(covf)
  );

  vrpv_div u_div_row (
    .clk_i(clk_i),
    .en_i (rdy[FRONT_STAGES +: DIV_STEPS+1]),
    .num_i(proj.row_num),
    .den_i(proj.den),
    .mag_o(rmag),
    .neg_o(rneg),
    .ovf_o(rovf)
  );

  // The near clamp flag travels alongside the divider stages.
  always_ff @(posedge clk_i) begin
    if (rdy[FRONT_STAGES]) clamp_q[FRONT_STAGES] <= proj.clamped;
    for (int i = FRONT_STAGES + 1; i < NUM_STAGES; i++) begin
      if (rdy[i]) clamp_q[i] <= clamp_q[i-1];
    end
  end

  // Apply the sign and saturate to the signed 16-bit range.
  function automatic logic signed [COORD_W-1:0] sat_q(logic [QUO_W-1:0] m, logic neg,
                                                      logic ovf);
    logic signed [COORD_W-1:0] r;
    if (neg) begin
      r = (ovf || m > 16'd32768) ? 16'sh8000 : $signed(~m + 16'd1);
    end else begin
      r = (ovf || m > 16'd32767) ? 16'sh7fff : $signed(m);
    end
    return r;
  endfunction

  // Output register.
  always_ff @(posedge clk_i) begin
    if (rdy[NUM_STAGES-1]) begin
      sx_q <= sat_q(cmag, cneg, covf);
      sy_q <= sat_q(rmag, rneg, rovf);
    end
  end

  assign m_axis_tvalid = v_q[NUM_STAGES-1];
  assign m_axis_tdata  = {sy_q, sx_q};
  assign m_axis_tuser  = clamp_q[NUM_STAGES-1];

  // An empty output stage never holds back the input.
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

  // An accepted request occupies the first stage in the next cycle.
  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[0])
    else $error("accepted request lost at the first stage");

  // A taken result with nothing behind it leaves the output empty.
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !v_q[NUM_STAGES-2]) |=> !m_axis_tvalid)
    else $error("result repeated after it was taken");

endmodule

`default_nettype wire

FILE: tb/vertex_rotate_project_viewport_top_tb.sv
// Self-checking testbench of the vertex rotate, project and viewport pipeline.
`timescale 1ns / 1ps

module vertex_rotate_project_viewport_top_tb;
  import vrpv_pkg::*;

  localparam int WIN_W     = 600;
  localparam int WIN_H     = 600;
  localparam int TAB_BITS  = 10;
  localparam int LATENCY   = 20;
  localparam longint NEAR_Q27 = 134218;
  localparam int MAX_CYCLES = 400000;

  typedef struct packed {
    logic signed [15:0] vz;
    logic signed [15:0] vy;
    logic signed [15:0] vx;
  } vertex_t;

  typedef struct packed {
    logic               clamped;
    logic signed [15:0] sy;
    logic signed [15:0] sx;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  vertex_rotate_project_viewport_top uut (.*);

  // Predictor configuration copy.
  logic [15:0]        angle_q;
  logic signed [15:0] cam_dist_q;

  vertex_t vertex_pending[$];
  pixel_t  pixel_expected[$];
  int      error_count = 0;
  int      cycle_count = 0;
  bit      hold_off = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Quarter-wave sine in Q14, t in 0..16384.
  function automatic longint quarter_sin(longint t);
    longint x2, p, r;
    x2 = (t * t) <<< 2;
    p = SIN_C9;
    p = SIN_C7 - ((p * x2) >>> 30);
    p = SIN_C5 - ((p * x2) >>> 30);
    p = SIN_C3 - ((p * x2) >>> 30);
    p = SIN_C1 - ((p * x2) >>> 30);
    r = (p * t + (64'sd1 <<< 29)) >>> 30;
    if (r > 16384) r = 16384;
    if (r < 0) r = 0;
    return r;
  endfunction

  function automatic longint grid_sin(logic [15:0] a);
    logic [1:0] q;
    longint r, s;
    q = a[15:14];
    r = longint'(a[13:0]);
    if (q[0]) r = 16384 - r;
    s = quarter_sin(r);
    return q[1] ? -s : s;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic pixel_t project_vertex(vertex_t v);
    logic [15:0] a;
    longint sn, cs, x, y, z, xr, yr, d, den, col, row;
    pixel_t p;
    a = angle_q & ~((16'd1 << (16 - TAB_BITS)) - 16'd1);
    sn = grid_sin(a);
    cs = grid_sin(a + 16'd16384);
    x = v.vx; y = v.vy; z = v.vz;
    xr = x * cs - z * sn;
    yr = y * 16384;
    d = x * sn + z * cs + longint'(cam_dist_q) * 65536;
    p.clamped = 1'b0;
    if (d <= NEAR_Q27) begin
      d = NEAR_Q27;
      p.clamped = 1'b1;
    end
    den = 2 * d;
    col = ((xr + d) * WIN_W) / den;
    row = ((d - yr) * WIN_H) / den;
    p.sx = 16'(sat16(col));
    p.sy = 16'(sat16(row));
    return p;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Driver: offers queued vertices with random gaps.
  int   send_gap = 0;
  logic calm_send = 1'b0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pixel_expected.push_back(project_vertex(vertex_t'(s_axis_tdata)));
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (vertex_pending.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= vertex_pending.pop_front();
        send_gap <= calm_send ? 0 : gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction.
  int   recv_gap = 0;
  pixel_t got_px, want_px;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      got_px = {m_axis_tuser, m_axis_tdata};
      if (pixel_expected.size() == 0) begin
        report_mismatch("unexpected result", got_px.sx, 0);
      end else begin
        want_px = pixel_expected.pop_front();
        if (got_px.sx !== want_px.sx) report_mismatch("screen_x", got_px.sx, want_px.sx);
        if (got_px.sy !== want_px.sy) report_mismatch("screen_y", got_px.sy, want_px.sy);
        if (got_px.clamped !== want_px.clamped)
          report_mismatch("near_clamped", got_px.clamped, want_px.clamped);
      end
    end
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      recv_gap <= calm_send ? 0 : gap_len();
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout waiting for results");
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_vertex(int x, int y, int z);
    vertex_t v;
    v.vx = 16'(x); v.vy = 16'(y); v.vz = 16'(z);
    vertex_pending.push_back(v);
  endtask

  // Sampled at the falling edge so that the driver's updates have settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (vertex_pending.size() > 0 || s_axis_tvalid || pixel_expected.size() > 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Register write, applied to the predictor copy at the same edge.
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_ROT_ANGLE) angle_q = val;
    else cam_dist_q = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random vertex: mostly moderate coordinates, some full range.
  task automatic push_random_vertex();
    if ($urandom_range(0, 3) == 0)
      push_vertex($urandom, $urandom, $urandom);
    else
      push_vertex($urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                  $urandom_range(0, 16383) - 8192);
  endtask

  int phase;
  logic [15:0] angle_set[6] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'h2A5F, 16'hC3C0};
  logic [15:0] dist_set[6]  = '{16'h7FFF, 16'h8000, 16'h1400, 16'h0000, 16'h0800, 16'h0042};

  initial begin
    angle_q = ROT_RESET;
    cam_dist_q = CAM_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed vertices at reset configuration: extremes, centre, near clamp.
    push_vertex(0, 0, 0);
    push_vertex(32767, 32767, 32767);
    push_vertex(-32768, -32768, -32768);
    push_vertex(32767, -32768, 0);
    push_vertex(-32768, 32767, 0);
    push_vertex(0, 0, -32768);
    push_vertex(100, -100, -20480);
    push_vertex(8192, 8192, 8192);
    push_vertex(-8192, 0, 4096);
    push_vertex(16'h5555, 16'hAAAA, 16'h5555);
    push_vertex(16'hAAAA, 16'h5555, 16'hAAAA);
    wait_idle();
    write_reg(CFG_CAM_DIST, 16'h0000);
    push_vertex(0, 0, 0);
    push_vertex(1000, 1000, 1);
    push_vertex(1000, 1000, 2);
    push_vertex(-1, 1, 32767);
    wait_idle();

    // Random phases across angle and distance settings.
    for (phase = 0; phase < 6; phase++) begin
      write_reg(CFG_ROT_ANGLE, phase < 4 ? angle_set[phase] : 16'($urandom));
      write_reg(CFG_CAM_DIST, phase < 5 ? dist_set[phase] : 16'($urandom));
      calm_send = (phase == 2);
      if (phase == 1) begin
        hold_off = 1'b1;
        repeat (220) push_random_vertex();
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        repeat (220) push_random_vertex();
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
